// ===== rtl/gsdp_pkg.sv =====
package gsdp_pkg;

  // field and datapath widths
  localparam int ACT_W   = 16;
  localparam int WGT_W   = 8;
  localparam int SCL_W   = 16;
  localparam int PROD_W  = ACT_W + WGT_W;
  localparam int GACC_W  = 37;
  localparam int SPROD_W = GACC_W + SCL_W;
  localparam int ACC_W   = 48;
  localparam int SUM_W   = SPROD_W + 1;
  localparam int REG_W   = 14;
  localparam int REG_MAX = 16383;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 2'd2;

  // configuration reset values
  localparam logic [REG_W-1:0] RST_ROW_LENGTH  = 14'd4096;
  localparam logic [REG_W-1:0] RST_GROUP_SIZE  = 14'd32;
  localparam logic [REG_W-1:0] RST_GROUP_COUNT = 14'd128;

  // row accumulator limits
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN =
    {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture item, product and position flags
    logic acc;     // add product into group accumulator
    logic scale;   // multiply group sum by scale
    logic rowadd;  // saturating add into row accumulator
    logic emit;    // move row result to output register, clear row
  } gsdp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic row_end;
    logic grp_end;
  } gsdp_stat_t;

endpackage

// ===== rtl/group_scaled_int8_dot_product.sv =====
// Channel  | Direction | Handshake            | Payload
// in       | input     | in_valid / in_stall  | in_activation, in_weight, in_scale
// out      | output    | out_valid / out_stall| out_dot_sum, out_saturated
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item is loaded into the product register and added into the group
// accumulator; an item that closes a group then takes the group scale multiply
// and the saturating row add. An item that closes a row also loads the output
// register, waiting while the previous result is still stalled there.
// Reset (rst_n low, synchronous) restores the register defaults and clears the row.
// cfg_ready is always high; writes take effect for the next item.
module group_scaled_int8_dot_product #(
  parameter int MAX_ROW_LENGTH = 8192
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [gsdp_pkg::ACT_W-1:0]     in_activation,
  input  logic signed [gsdp_pkg::WGT_W-1:0]     in_weight,
  input  logic signed [gsdp_pkg::SCL_W-1:0]     in_scale,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gsdp_pkg::ACC_W-1:0]     out_dot_sum,
  output logic                                  out_saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gsdp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gsdp_pkg::REG_W-1:0]            cfg_data
);

  gsdp_pkg::gsdp_cmd_t  cmd;
  gsdp_pkg::gsdp_stat_t stat;

  assign cfg_ready = 1'b1;

  gsdp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  gsdp_dpath #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_activation (in_activation),
    .in_weight     (in_weight),
    .in_scale      (in_scale),
    .cmd           (cmd),
    .stat          (stat),
    .out_dot_sum   (out_dot_sum),
    .out_saturated (out_saturated)
  );

`ifndef SYNTH
  // one datapath command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.acc, cmd.scale, cmd.rowadd, cmd.emit}))
    else $error("more than one datapath command");

  // a taken item blocks the input channel in the next cycle
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while item in flight");

  // scale multiply is always followed by the row add
  a_scale_then_row: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scale |=> cmd.rowadd)
    else $error("row add missing after scale multiply");

  // a loaded result shows as a valid output beat
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("result loaded without output valid");
`endif

endmodule

// ===== rtl/gsdp_ctrl.sv =====
module gsdp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  gsdp_pkg::gsdp_stat_t stat,
  output gsdp_pkg::gsdp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ACC   = 5'b00010,
    S_SCALE = 5'b00100,
    S_ROW   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // sequencing and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = stat.grp_end ? S_SCALE : S_IDLE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.rowadd = 1'b1;
        state_nxt  = stat.row_end ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/gsdp_dpath.sv =====
module gsdp_dpath #(
  parameter int MAX_ROW_LENGTH = 8192
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic [gsdp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gsdp_pkg::REG_W-1:0]            cfg_data,
  input  logic signed [gsdp_pkg::ACT_W-1:0]     in_activation,
  input  logic signed [gsdp_pkg::WGT_W-1:0]     in_weight,
  input  logic signed [gsdp_pkg::SCL_W-1:0]     in_scale,
  input  gsdp_pkg::gsdp_cmd_t                   cmd,
  output gsdp_pkg::gsdp_stat_t                  stat,
  output logic signed [gsdp_pkg::ACC_W-1:0]     out_dot_sum,
  output logic                                  out_saturated
);

  localparam int EFF_MAX = (MAX_ROW_LENGTH > gsdp_pkg::REG_MAX) ?
                           gsdp_pkg::REG_MAX : MAX_ROW_LENGTH;
  localparam int CNT_W   = $clog2(EFF_MAX + 1);
  localparam int REG_W   = gsdp_pkg::REG_W;

  // configuration
  logic [REG_W-1:0] row_length_r, group_size_r, group_count_r;

  // position counters
  logic [CNT_W-1:0] elem_r, idx_r;
  logic [REG_W-1:0] grp_idx_r;
  logic             row_end_r, grp_end_r, add_en_r;

  // arithmetic
  logic signed [gsdp_pkg::PROD_W-1:0]  prod_mul, prod_r;
  logic signed [gsdp_pkg::SCL_W-1:0]   scale_r;
  logic signed [gsdp_pkg::GACC_W-1:0]  gacc_r, prod_ext;
  logic signed [gsdp_pkg::SPROD_W-1:0] sprod_mul, sprod_r;
  logic signed [gsdp_pkg::ACC_W-1:0]   row_acc_r, dot_sum_r;
  logic signed [gsdp_pkg::SUM_W-1:0]   row_sum;
  logic                                clip_r, sat_out_r;

  logic [REG_W-1:0] rl_eff, gs_eff;
  logic [CNT_W-1:0] elem_inc, idx_inc;
  logic             item_row_end, item_grp_end, item_add_en;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r  <= gsdp_pkg::RST_ROW_LENGTH;
      group_size_r  <= gsdp_pkg::RST_GROUP_SIZE;
      group_count_r <= gsdp_pkg::RST_GROUP_COUNT;
    end else if (cfg_valid) begin
      case (cfg_index)
        gsdp_pkg::CFG_ROW_LENGTH:  row_length_r  <= cfg_data;
        gsdp_pkg::CFG_GROUP_SIZE:  group_size_r  <= cfg_data;
        gsdp_pkg::CFG_GROUP_COUNT: group_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective lengths and position flags for the arriving item
  always_comb begin
    if (row_length_r == '0) begin
      rl_eff = REG_W'(1);
    end else if (row_length_r > REG_W'(EFF_MAX)) begin
      rl_eff = REG_W'(EFF_MAX);
    end else begin
      rl_eff = row_length_r;
    end
    gs_eff       = (group_size_r == '0) ? REG_W'(1) : group_size_r;
    elem_inc     = elem_r + CNT_W'(1);
    idx_inc      = idx_r + CNT_W'(1);
    item_row_end = REG_W'(elem_inc) >= rl_eff;
    item_grp_end = item_row_end || (REG_W'(idx_inc) >= gs_eff);
    item_add_en  = grp_idx_r < group_count_r;
  end

  // counters advance as the item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_r    <= '0;
      idx_r     <= '0;
      grp_idx_r <= '0;
      row_end_r <= 1'b0;
      grp_end_r <= 1'b0;
      add_en_r  <= 1'b0;
    end else if (cmd.load) begin
      row_end_r <= item_row_end;
      grp_end_r <= item_grp_end;
      add_en_r  <= item_add_en;
      if (item_row_end) begin
        elem_r    <= '0;
        idx_r     <= '0;
        grp_idx_r <= '0;
      end else begin
        elem_r <= elem_inc;
        if (item_grp_end) begin
          idx_r <= '0;
          if (grp_idx_r != REG_W'(gsdp_pkg::REG_MAX)) begin
            grp_idx_r <= grp_idx_r + REG_W'(1);
          end
        end else begin
          idx_r <= idx_inc;
        end
      end
    end
  end

  // element product, registered
  assign prod_mul =
    $signed({{gsdp_pkg::WGT_W{in_activation[gsdp_pkg::ACT_W-1]}}, in_activation}) *
    $signed({{gsdp_pkg::ACT_W{in_weight[gsdp_pkg::WGT_W-1]}}, in_weight});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod_r  <= prod_mul;
      scale_r <= in_scale;
    end
  end

  // group accumulate and group scale multiply
  assign prod_ext  = {{(gsdp_pkg::GACC_W-gsdp_pkg::PROD_W){prod_r[gsdp_pkg::PROD_W-1]}},
                      prod_r};
  assign sprod_mul =
    $signed({{gsdp_pkg::SCL_W{gacc_r[gsdp_pkg::GACC_W-1]}}, gacc_r}) *
    $signed({{gsdp_pkg::GACC_W{scale_r[gsdp_pkg::SCL_W-1]}}, scale_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gacc_r <= '0;
    end else if (cmd.acc) begin
      gacc_r <= gacc_r + prod_ext;
    end else if (cmd.scale) begin
      gacc_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      sprod_r <= sprod_mul;
    end
  end

  // saturating row accumulate and result hand-off
  assign row_sum = {{(gsdp_pkg::SUM_W-gsdp_pkg::ACC_W){row_acc_r[gsdp_pkg::ACC_W-1]}},
                    row_acc_r}
                 + {sprod_r[gsdp_pkg::SPROD_W-1], sprod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_acc_r <= '0;
      clip_r    <= 1'b0;
    end else if (cmd.rowadd && add_en_r) begin
      if (row_sum > gsdp_pkg::SUM_MAX) begin
        row_acc_r <= gsdp_pkg::ACC_MAX;
        clip_r    <= 1'b1;
      end else if (row_sum < gsdp_pkg::SUM_MIN) begin
        row_acc_r <= gsdp_pkg::ACC_MIN;
        clip_r    <= 1'b1;
      end else begin
        row_acc_r <= row_sum[gsdp_pkg::ACC_W-1:0];
      end
    end else if (cmd.emit) begin
      row_acc_r <= '0;
      clip_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      dot_sum_r <= row_acc_r;
      sat_out_r <= clip_r;
    end
  end

  assign stat.row_end  = row_end_r;
  assign stat.grp_end  = grp_end_r;
  assign out_dot_sum   = dot_sum_r;
  assign out_saturated = sat_out_r;

endmodule
